>>> design/median_filter_3x3_stream_assert.svh
// Assertion macros shared by the median filter RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MEDIAN_FILTER_3X3_STREAM_ASSERT_SVH
`define MEDIAN_FILTER_3X3_STREAM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MF3S_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MF3S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mfs_pkg.sv
// Package for the 3x3 median filter: sizes, codes and shared types.
// Used by every module of the block but mfs_ram; depends on nothing.
package mfs_pkg;

  // Largest plane the line stores are sized for.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Field and register widths.
  localparam int PIX_W = 8;
  localparam int DIM_W = 12;

  // Column counters index the line stores; row counters also count the tail rows.
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  // Common width for comparing positions against the frame size.
  localparam int CMP_A = (COL_W > DIM_W) ? COL_W : DIM_W;
  localparam int CMP_W = ((CMP_A > ROW_W) ? CMP_A : ROW_W) + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Request command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Reset frame size.
  localparam int RESET_WIDTH  = 176;
  localparam int RESET_HEIGHT = 144;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 window, index row*3+column, column 2 is the newest sample.
  typedef logic [8:0][PIX_W-1:0] win_t;

  // Position bookkeeping for one request, produced by the control unit.
  typedef struct packed {
    logic             primed;
    logic             interior;
    logic             last;
    logic [COL_W-1:0] col;
  } pos_info_t;

endpackage

>>> design/mfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the two line stores.
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/mfs_ctrl.sv
// Control unit: frame size registers, input and output position counters.
// Depends on mfs_pkg.
module mfs_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfs_pkg::DIM_W-1:0]      cfg_wdata,
  input  logic                           accept,
  output mfs_pkg::pos_info_t             info
);
  import mfs_pkg::*;

  // Clamp a frame dimension to [3, hi].
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    logic [CMP_W-1:0] ve;
    logic [CMP_W-1:0] he;
    ve = CMP_W'(v);
    he = CMP_W'(hi);
    if (ve < CMP_W'(3)) begin
      return DIM_W'(3);
    end else if (ve > he) begin
      return DIM_W'(hi);
    end
    return v;
  endfunction

  logic [DIM_W-1:0] width_r,   width_nxt;
  logic [DIM_W-1:0] height_r,  height_nxt;
  logic [COL_W-1:0] in_col_r,  in_col_nxt;
  logic [ROW_W-1:0] in_row_r,  in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic [COL_W-1:0] col_cur;
  logic [CMP_W-1:0] w_e, h_e;
  logic             in_wrap, out_wrap;
  logic             primed, interior, last;

  // Position decode for the current request.
  always_comb begin
    w_e      = CMP_W'(width_r);
    h_e      = CMP_W'(height_r);
    col_cur  = (CMP_W'(in_col_r) >= w_e) ? '0 : in_col_r;
    primed   = (in_row_r >= ROW_W'(2)) ||
               ((in_row_r == ROW_W'(1)) && (col_cur != '0));
    interior = (out_row_r != '0) && (CMP_W'(out_row_r) + CMP_W'(1) < h_e) &&
               (out_col_r != '0) && (CMP_W'(out_col_r) + CMP_W'(1) < w_e);
    last     = (CMP_W'(out_row_r) + CMP_W'(1) >= h_e) &&
               (CMP_W'(out_col_r) + CMP_W'(1) >= w_e);
    in_wrap  = (CMP_W'(col_cur) + CMP_W'(1) >= w_e);
    out_wrap = (CMP_W'(out_col_r) + CMP_W'(1) >= w_e);
  end

  assign info = '{primed: primed, interior: interior, last: last, col: col_cur};

  // Next-state logic: a register write restarts the frame, so does the last result.
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_wr_en) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        width_nxt = clamp_dim(cfg_wdata, MAX_WIDTH);
      end else begin
        height_nxt = clamp_dim(cfg_wdata, MAX_HEIGHT);
      end
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (accept) begin
      if (primed && last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        if (in_wrap) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + ROW_W'(1);
        end else begin
          in_col_nxt = col_cur + COL_W'(1);
        end
        if (primed) begin
          if (out_wrap) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + ROW_W'(1);
          end else begin
            out_col_nxt = out_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= clamp_dim(DIM_W'(RESET_WIDTH), MAX_WIDTH);
      height_r  <= clamp_dim(DIM_W'(RESET_HEIGHT), MAX_HEIGHT);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

>>> design/mfs_median.sv
// Median of a 3x3 window by a compare-exchange network.
// Depends on mfs_pkg for the window and pixel types.
module mfs_median (
  input  mfs_pkg::win_t win,
  output mfs_pkg::pix_t median
);
  import mfs_pkg::*;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pix_t lo [3];
  pix_t md [3];
  pix_t hi [3];
  pix_t lo_max, md_med, hi_min;

  // Sort each row, then take the median of the row extremes and middles.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo[r] = min2(min2(win[r*3], win[r*3+1]), win[r*3+2]);
      hi[r] = max2(max2(win[r*3], win[r*3+1]), win[r*3+2]);
      md[r] = med3(win[r*3], win[r*3+1], win[r*3+2]);
    end
    lo_max = max2(max2(lo[0], lo[1]), lo[2]);
    hi_min = min2(min2(hi[0], hi[1]), hi[2]);
    md_med = med3(md[0], md[1], md[2]);
  end

  assign median = med3(lo_max, md_med, hi_min);

endmodule

>>> design/median_filter_3x3_stream.sv
// 3x3 median filter over one 8-bit pixel plane streamed in raster order.
// Channels: the input takes requests (in_command, in_pixel_in) on in_valid/in_ready,
// where a drain command takes a pixel position with value zero. Results
// (out_pixel_out, out_last_of_frame) leave on out_valid/out_ready. The frame size
// is written through cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. A write clamps the
// value to [3, MAX] and restarts the frame. Throughput: one request per clock while
// the receiver takes results. A request enters the input stage together with the
// line-store read; as it advances, it shifts the window and writes the line stores;
// the output register then takes the median. A result appears one line plus one
// pixel behind the input stream. A frame needs width+1 extra requests (drains) to
// flush its last line.
// Interior pixels get the median of the 3x3 neighborhood; border pixels pass.
// Reset clears all positions and the window; line stores keep their contents.
// When the receiver stalls, the result holds and the stages fill; in_ready
// drops only when all three stages hold work.
module median_filter_3x3_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [mfs_pkg::PIX_W-1:0]      in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mfs_pkg::PIX_W-1:0]      out_pixel_out,
  output logic                           out_last_of_frame,
  input  logic                           cfg_wr_en,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfs_pkg::DIM_W-1:0]      cfg_wdata
);
  import mfs_pkg::*;

  pos_info_t        info;
  logic             in_accept;
  logic             s1_adv, s2_free, out_load;
  pix_t             x_in;

  logic             s1_valid_r, s1_valid_nxt;
  pix_t             s1_x_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_primed_r, s1_interior_r, s1_last_r;

  logic             s2_valid_r, s2_valid_nxt;
  logic             s2_interior_r, s2_last_r;
  win_t             window_r, window_nxt;

  logic             out_valid_r, out_valid_nxt;
  pix_t             out_pixel_r;
  logic             out_last_r;

  pix_t             top, mid, median;

  // Handshake and stage flow.
  assign out_load  = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_free   = !s2_valid_r || out_load;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign x_in      = (in_command == CMD_DRAIN) ? '0 : in_pixel_in;

  // Frame size and position counters.
  mfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .info      (info)
  );

  // Line store holding the previous line.
  mfs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_mid (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_x_r),
    .rd_en   (in_accept),
    .rd_addr (info.col),
    .rd_data (mid)
  );

  // Line store holding the line before that.
  mfs_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_top (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (mid),
    .rd_en   (in_accept),
    .rd_addr (info.col),
    .rd_data (top)
  );

  // Window shift: one new column from the two line stores and the sample.
  always_comb begin
    window_nxt = window_r;
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        window_nxt[r*3]   = window_r[r*3+1];
        window_nxt[r*3+1] = window_r[r*3+2];
      end
      window_nxt[2] = top;
      window_nxt[5] = mid;
      window_nxt[8] = s1_x_r;
    end
  end

  mfs_median u_median (
    .win    (window_r),
    .median (median)
  );

  // Valid bits of the three stages.
  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    s2_valid_nxt  = s1_adv ? s1_primed_r : (out_load ? 1'b0 : s2_valid_r);
    out_valid_nxt = out_load ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x_r        <= x_in;
      s1_col_r      <= info.col;
      s1_primed_r   <= info.primed;
      s1_interior_r <= info.interior;
      s1_last_r     <= info.last;
    end
    if (s1_adv) begin
      s2_interior_r <= s1_interior_r;
      s2_last_r     <= s1_last_r;
    end
    if (out_load) begin
      out_pixel_r <= s2_interior_r ? median : window_r[4];
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = out_pixel_r;
  assign out_last_of_frame = out_last_r;

`include "median_filter_3x3_stream_assert.svh"

  // The last request of a frame and the first of the next both sit at column zero;
  // that read only feeds border results, so the pair is left out of the check.
  `MF3S_ASSERT_SAME(a_no_rw_clash, s1_adv && in_accept && !s1_last_r, s1_col_r != info.col, "line store read and write collide")
  `MF3S_ASSERT_NEXT(a_window_held, s2_valid_r && !out_load, $stable(window_r), "window shifted over a pending result")
  `MF3S_ASSERT_NEXT(a_s1_held, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_col_r), "input stage lost a request")

endmodule
